FILE: hw/rtl/scb_pkg.sv
// Shared types, constants and helpers for the straddling checkerboard codec.
// Used by scb_table, straddling_checkerboard_codec and the testbench; depends on nothing.
package scb_pkg;

	localparam int TABLE_SLOTS = 30;
	localparam int POS_W = $clog2(TABLE_SLOTS + 1);
	localparam int ROW_SLOTS = 10;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);

	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] ASCII_NINE = 8'h39;
	localparam logic [7:0] ASCII_SPACE = 8'h20;

	localparam logic [3:0] BLANK_A_RESET = 4'd2;
	localparam logic [3:0] BLANK_B_RESET = 4'd6;

	localparam logic CFG_BLANK_A = 1'b0;
	localparam logic CFG_BLANK_B = 1'b1;

	typedef enum logic [1:0] {
		MODE_CLEAR  = 2'd0,
		MODE_INSERT = 2'd1,
		MODE_ENCODE = 2'd2,
		MODE_DECODE = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		KIND_DIGIT = 2'd0,
		KIND_CHAR  = 2'd1,
		KIND_SPACE = 2'd2,
		KIND_ERROR = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ROW_NONE = 2'd0,
		ROW_A    = 2'd1,
		ROW_B    = 2'd2,
		ROW_BAD  = 2'd3
	} row_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] value;
		logic       last;
	} result_t;

	typedef struct packed {
		logic             clear;
		logic             wr_en;
		logic [POS_W-1:0] wr_idx;
		logic [7:0]       wr_data;
		logic [7:0]       key;
		logic [POS_W-1:0] rd_idx;
	} tbl_ctrl_t;

	typedef struct packed {
		logic             hit;
		logic [POS_W-1:0] hit_pos;
		logic [7:0]       rd_data;
	} tbl_stat_t;

	function automatic logic is_blank(input logic [POS_W-1:0] pos, input logic [3:0] a,
	                                  input logic [3:0] b);
		return (pos < POS_W'(ROW_SLOTS)) &&
		       (pos == POS_W'(a) || pos == POS_W'(b));
	endfunction

	// Two blank digits can sit side by side, so at most two steps.
	function automatic logic [POS_W-1:0] skip_blanks(input logic [POS_W-1:0] pos,
	                                                 input logic [3:0] a,
	                                                 input logic [3:0] b);
		logic [POS_W-1:0] p1;
		p1 = is_blank(pos, a, b) ? pos + POS_W'(1) : pos;
		return is_blank(p1, a, b) ? p1 + POS_W'(1) : p1;
	endfunction

endpackage

FILE: hw/rtl/straddling_checkerboard_codec.sv
// Top level of the straddling checkerboard codec: input register, single-pass
// encode/decode/insert logic and a four-beat result queue. Depends on scb_pkg, scb_table.
//
// s_* carries one beat per symbol: s_tuser the mode (clear, insert, encode, decode),
// s_tdata the symbol byte. m_* returns results: m_tuser the kind (digit, character,
// space, error), m_tdata the digit or character, m_tlast the final result of a beat.
// Clear, insert and a decode beat that only records a prefix digit return nothing.
// cfg_we writes cfg_data to blank digit a (cfg_index 0) or b (cfg_index 1); write
// only while the codec is idle.
// A beat accepted at one edge is held in the input register until it is processed,
// and its results are written into the queue and offered on m_* from there.
// Processing needs two free queue entries, so the rate is set by the drain of one
// result beat per cycle while m_tready is high.
// arst_n empties the table, the queue and the input register, clears any pending
// prefix and sets the blank digits to 2 and 6.
// While m_tready is low the queue fills, processing stops once fewer than two
// entries are free and s_tready drops while the input register is full.
module straddling_checkerboard_codec (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] symbol
	input  logic [1:0]  s_tuser,   // [1:0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] value
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [3:0]  cfg_data
);

	logic                       valid_s1;
	scb_pkg::mode_t             mode_s1;
	logic [7:0]                 symbol_s1;
	logic [3:0]                 blank_a_q;
	logic [3:0]                 blank_b_q;
	logic [scb_pkg::POS_W-1:0]  fill_pos_q;
	logic [scb_pkg::POS_W-1:0]  fill_pos_d;
	logic [scb_pkg::POS_W-1:0]  fill_skip;
	scb_pkg::row_t              pending_q;
	scb_pkg::row_t              pending_d;
	scb_pkg::tbl_ctrl_t         tbl_ctrl;
	scb_pkg::tbl_stat_t         tbl_stat;
	scb_pkg::result_t           res0;
	scb_pkg::result_t           res1;
	logic [1:0]                 res_n;
	logic                       proc_fire;
	logic                       is_digit;
	logic [3:0]                 digit;
	logic [scb_pkg::POS_W-1:0]  units;
	scb_pkg::result_t           fifo_q [scb_pkg::FIFO_DEPTH];
	logic [scb_pkg::FIFO_AW-1:0] wr_ptr_q;
	logic [scb_pkg::FIFO_AW-1:0] rd_ptr_q;
	logic [scb_pkg::FIFO_AW:0]   count_q;
	logic                       pop;
	logic                       push0;
	logic                       push1;

	assign proc_fire = valid_s1 && (count_q <= (scb_pkg::FIFO_AW+1)'(scb_pkg::FIFO_DEPTH - 2));
	assign s_tready = !valid_s1 || proc_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			mode_s1 <= scb_pkg::mode_t'(s_tuser);
			symbol_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blank_a_q <= scb_pkg::BLANK_A_RESET;
			blank_b_q <= scb_pkg::BLANK_B_RESET;
		end else if (cfg_we) begin
			if (cfg_index == scb_pkg::CFG_BLANK_A) begin
				blank_a_q <= cfg_data;
			end
			if (cfg_index == scb_pkg::CFG_BLANK_B) begin
				blank_b_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_pos_q <= '0;
			pending_q <= scb_pkg::ROW_NONE;
		end else if (proc_fire) begin
			fill_pos_q <= fill_pos_d;
			pending_q <= pending_d;
		end
	end

	scb_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (tbl_ctrl),
		.stat   (tbl_stat)
	);

	assign is_digit = symbol_s1 inside {[scb_pkg::ASCII_ZERO:scb_pkg::ASCII_NINE]};
	assign digit = 4'(symbol_s1 - scb_pkg::ASCII_ZERO);
	assign fill_skip = scb_pkg::skip_blanks(fill_pos_q, blank_a_q, blank_b_q);

	always_comb begin
		if (tbl_stat.hit_pos >= scb_pkg::POS_W'(2 * scb_pkg::ROW_SLOTS)) begin
			units = tbl_stat.hit_pos - scb_pkg::POS_W'(2 * scb_pkg::ROW_SLOTS);
		end else if (tbl_stat.hit_pos >= scb_pkg::POS_W'(scb_pkg::ROW_SLOTS)) begin
			units = tbl_stat.hit_pos - scb_pkg::POS_W'(scb_pkg::ROW_SLOTS);
		end else begin
			units = tbl_stat.hit_pos;
		end
	end

	always_comb begin
		tbl_ctrl.clear = 1'b0;
		tbl_ctrl.wr_en = 1'b0;
		tbl_ctrl.wr_idx = fill_skip;
		tbl_ctrl.wr_data = symbol_s1;
		tbl_ctrl.key = symbol_s1;
		case (pending_q)
			scb_pkg::ROW_A: tbl_ctrl.rd_idx = scb_pkg::POS_W'(scb_pkg::ROW_SLOTS) +
			                                  scb_pkg::POS_W'(digit);
			scb_pkg::ROW_B: tbl_ctrl.rd_idx = scb_pkg::POS_W'(2 * scb_pkg::ROW_SLOTS) +
			                                  scb_pkg::POS_W'(digit);
			default:        tbl_ctrl.rd_idx = scb_pkg::POS_W'(digit);
		endcase
		fill_pos_d = fill_pos_q;
		pending_d = scb_pkg::ROW_NONE;
		res_n = 2'd0;
		res0 = '{kind: scb_pkg::KIND_ERROR, value: 8'd0, last: 1'b1};
		res1 = '{kind: scb_pkg::KIND_ERROR, value: 8'd0, last: 1'b1};
		case (mode_s1)
			scb_pkg::MODE_CLEAR: begin
				tbl_ctrl.clear = proc_fire;
				fill_pos_d = scb_pkg::skip_blanks('0, blank_a_q, blank_b_q);
			end
			scb_pkg::MODE_INSERT: begin
				fill_pos_d = fill_skip;
				if (symbol_s1 != 8'd0 && fill_skip < scb_pkg::POS_W'(scb_pkg::TABLE_SLOTS) &&
				    !tbl_stat.hit) begin
					tbl_ctrl.wr_en = proc_fire;
					fill_pos_d = fill_skip + scb_pkg::POS_W'(1);
				end
			end
			scb_pkg::MODE_ENCODE: begin
				res_n = 2'd1;
				if (symbol_s1 == scb_pkg::ASCII_SPACE) begin
					res0.kind = scb_pkg::KIND_SPACE;
				end else if (symbol_s1 == 8'd0 || !tbl_stat.hit) begin
					res0.kind = scb_pkg::KIND_ERROR;
				end else if (tbl_stat.hit_pos < scb_pkg::POS_W'(scb_pkg::ROW_SLOTS)) begin
					res0.kind = scb_pkg::KIND_DIGIT;
					res0.value = 8'(tbl_stat.hit_pos);
				end else begin
					res_n = 2'd2;
					res0.kind = scb_pkg::KIND_DIGIT;
					res0.last = 1'b0;
					res0.value = (tbl_stat.hit_pos < scb_pkg::POS_W'(2 * scb_pkg::ROW_SLOTS)) ?
					             8'(blank_a_q) : 8'(blank_b_q);
					res1.kind = scb_pkg::KIND_DIGIT;
					res1.value = 8'(units);
				end
			end
			scb_pkg::MODE_DECODE: begin
				res_n = 2'd1;
				if (symbol_s1 == scb_pkg::ASCII_SPACE) begin
					if (pending_q != scb_pkg::ROW_NONE) begin
						res_n = 2'd2;
						res0.last = 1'b0;
						res1.kind = scb_pkg::KIND_SPACE;
					end else begin
						res0.kind = scb_pkg::KIND_SPACE;
					end
				end else if (!is_digit) begin
					res0.kind = scb_pkg::KIND_ERROR;
				end else if (pending_q == scb_pkg::ROW_NONE && digit == blank_a_q) begin
					res_n = 2'd0;
					pending_d = scb_pkg::ROW_A;
				end else if (pending_q == scb_pkg::ROW_NONE && digit == blank_b_q) begin
					res_n = 2'd0;
					pending_d = scb_pkg::ROW_B;
				end else if (tbl_stat.rd_data != 8'd0) begin
					res0.kind = scb_pkg::KIND_CHAR;
					res0.value = tbl_stat.rd_data;
				end
			end
			default: begin
				res_n = 2'd0;
			end
		endcase
	end

	assign pop = m_tvalid && m_tready;
	assign push0 = proc_fire && (res_n != 2'd0);
	assign push1 = proc_fire && (res_n == 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + scb_pkg::FIFO_AW'(1);
			end
			if (push0) begin
				wr_ptr_q <= wr_ptr_q + scb_pkg::FIFO_AW'(res_n);
			end
			count_q <= count_q + (scb_pkg::FIFO_AW+1)'(proc_fire ? res_n : 2'd0) -
			           (scb_pkg::FIFO_AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push0) begin
			fifo_q[wr_ptr_q] <= res0;
		end
		if (push1) begin
			fifo_q[wr_ptr_q + scb_pkg::FIFO_AW'(1)] <= res1;
		end
	end

	assign m_tvalid = (count_q != '0);
	assign m_tuser = fifo_q[rd_ptr_q].kind;
	assign m_tdata = fifo_q[rd_ptr_q].value;
	assign m_tlast = fifo_q[rd_ptr_q].last;

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (scb_pkg::FIFO_AW+1)'(scb_pkg::FIFO_DEPTH))
		else $error("result queue overflow");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_pos_q <= scb_pkg::POS_W'(scb_pkg::TABLE_SLOTS))
		else $error("fill position beyond table");

	a_pending_legal: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != scb_pkg::ROW_BAD)
		else $error("illegal pending row");

	a_pending_consumed: assert property (@(posedge clk) disable iff (!arst_n)
		(proc_fire && mode_s1 == scb_pkg::MODE_DECODE && pending_q != scb_pkg::ROW_NONE)
		|=> pending_q == scb_pkg::ROW_NONE)
		else $error("pending row not consumed");

endmodule

FILE: hw/rtl/scb_table.sv
// Checkerboard table storage: entries with per-slot valid bits, parallel key match,
// one indexed read and one write port. Depends on scb_pkg.
module scb_table (
	input  logic              clk,
	input  logic              arst_n,
	input  scb_pkg::tbl_ctrl_t ctrl,
	output scb_pkg::tbl_stat_t stat
);

	logic [7:0]                     entry_q [scb_pkg::TABLE_SLOTS];
	logic [scb_pkg::TABLE_SLOTS-1:0] valid_q;
	logic [scb_pkg::TABLE_SLOTS-1:0] match;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctrl.clear) begin
			valid_q <= '0;
		end else if (ctrl.wr_en) begin
			valid_q[ctrl.wr_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.wr_en && !ctrl.clear) begin
			entry_q[ctrl.wr_idx] <= ctrl.wr_data;
		end
	end

	always_comb begin
		for (int i = 0; i < scb_pkg::TABLE_SLOTS; i++) begin
			match[i] = valid_q[i] && (entry_q[i] == ctrl.key);
		end
	end

	always_comb begin
		stat.hit = |match;
		stat.hit_pos = '0;
		for (int i = scb_pkg::TABLE_SLOTS - 1; i >= 0; i--) begin
			if (match[i]) begin
				stat.hit_pos = scb_pkg::POS_W'(i);
			end
		end
		if (ctrl.rd_idx < scb_pkg::POS_W'(scb_pkg::TABLE_SLOTS) && valid_q[ctrl.rd_idx]) begin
			stat.rd_data = entry_q[ctrl.rd_idx];
		end else begin
			stat.rd_data = '0;
		end
	end

endmodule

FILE: sim/tb_straddling_checkerboard_codec.sv
// Self-checking testbench for straddling_checkerboard_codec: clear, insert, encode and
// decode beats are predicted by an in-bench checkerboard model and compared result by result.
// Depends on scb_pkg and the codec RTL.
`timescale 1ns / 1ps

module tb_straddling_checkerboard_codec;

	localparam int STALL_LIMIT = 4000;
	localparam int PHASES = 8;

	typedef struct {
		scb_pkg::mode_t mode;
		logic [7:0]     symbol;
	} codec_beat_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'd0;   // [7:0] symbol
	logic [1:0] s_tuser = 2'd0;   // [1:0] mode
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;          // [7:0] value
	logic [1:0] m_tuser;          // [1:0] kind
	logic       m_tlast;
	logic       cfg_we = 1'b0;
	logic       cfg_index = scb_pkg::CFG_BLANK_A;
	logic [3:0] cfg_data = 4'd0;

	straddling_checkerboard_codec uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// checkerboard model state
	logic [7:0]     board [scb_pkg::TABLE_SLOTS];
	int             next_slot;
	scb_pkg::row_t  held_row;
	logic [3:0]     blank_a = scb_pkg::BLANK_A_RESET;
	logic [3:0]     blank_b = scb_pkg::BLANK_B_RESET;

	codec_beat_t      stim_q[$];
	scb_pkg::result_t expected_results[$];
	logic [7:0]       key_pool[$];

	int  beats_queued = 0;
	int  beats_in = 0;
	int  beats_out = 0;
	int  err_count = 0;
	int  quiet_cycles = 0;
	int  idle_pct = 0;
	int  send_gap = 0;
	int  stall_left = 0;
	bit  beat_taken = 1'b0;

	function automatic bit row0_blank(int pos);
		return pos < scb_pkg::ROW_SLOTS && (pos == int'(blank_a) || pos == int'(blank_b));
	endfunction

	function automatic void advance_fill();
		while (next_slot < scb_pkg::TABLE_SLOTS && row0_blank(next_slot))
			next_slot++;
	endfunction

	function automatic void wipe_board();
		foreach (board[i])
			board[i] = 8'd0;
		next_slot = 0;
		advance_fill();
		held_row = scb_pkg::ROW_NONE;
	endfunction

	function automatic int find_slot(logic [7:0] sym);
		for (int p = 0; p < scb_pkg::TABLE_SLOTS; p++)
			if (board[p] == sym)
				return p;
		return -1;
	endfunction

	function automatic void add_result(scb_pkg::kind_t k, logic [7:0] v, logic l);
		scb_pkg::result_t r;
		r.kind = k;
		r.value = v;
		r.last = l;
		expected_results.push_back(r);
	endfunction

	function automatic void slot_result(int idx);
		logic [7:0] c;
		c = (idx < scb_pkg::TABLE_SLOTS) ? board[idx] : 8'd0;
		if (c == 8'd0)
			add_result(scb_pkg::KIND_ERROR, 8'd0, 1'b1);
		else
			add_result(scb_pkg::KIND_CHAR, c, 1'b1);
	endfunction

	function automatic void checkerboard_step(scb_pkg::mode_t m, logic [7:0] sym);
		int            p;
		int            d;
		scb_pkg::row_t row;
		case (m)
			scb_pkg::MODE_CLEAR: begin
				wipe_board();
			end
			scb_pkg::MODE_INSERT: begin
				held_row = scb_pkg::ROW_NONE;
				advance_fill();
				if (sym != 8'd0 && next_slot < scb_pkg::TABLE_SLOTS && find_slot(sym) < 0) begin
					board[next_slot] = sym;
					next_slot++;
				end
			end
			scb_pkg::MODE_ENCODE: begin
				held_row = scb_pkg::ROW_NONE;
				p = (sym == 8'd0) ? -1 : find_slot(sym);
				if (sym == scb_pkg::ASCII_SPACE)
					add_result(scb_pkg::KIND_SPACE, 8'd0, 1'b1);
				else if (p < 0)
					add_result(scb_pkg::KIND_ERROR, 8'd0, 1'b1);
				else if (p < scb_pkg::ROW_SLOTS)
					add_result(scb_pkg::KIND_DIGIT, 8'(p), 1'b1);
				else begin
					add_result(scb_pkg::KIND_DIGIT, {4'd0, (p < 20) ? blank_a : blank_b}, 1'b0);
					add_result(scb_pkg::KIND_DIGIT, 8'(p % 10), 1'b1);
				end
			end
			default: begin
				row = held_row;
				held_row = scb_pkg::ROW_NONE;
				if (sym == scb_pkg::ASCII_SPACE) begin
					if (row != scb_pkg::ROW_NONE)
						add_result(scb_pkg::KIND_ERROR, 8'd0, 1'b0);
					add_result(scb_pkg::KIND_SPACE, 8'd0, 1'b1);
				end else if (!(sym inside {[scb_pkg::ASCII_ZERO:scb_pkg::ASCII_NINE]}))
					add_result(scb_pkg::KIND_ERROR, 8'd0, 1'b1);
				else begin
					d = int'(sym - scb_pkg::ASCII_ZERO);
					if (row != scb_pkg::ROW_NONE)
						slot_result(int'(row) * 10 + d);
					else if (d == int'(blank_a))
						held_row = scb_pkg::ROW_A;
					else if (d == int'(blank_b))
						held_row = scb_pkg::ROW_B;
					else
						slot_result(d);
				end
			end
		endcase
	endfunction

	initial wipe_board();

	task automatic report_mismatch(string what, int got, int want);
		err_count++;
		if (err_count <= 100)
			$display("[%0t] result beat %0d: %s got %0h expected %0h",
			         $realtime, beats_out, what, got, want);
	endtask

	// sample both streams and the config port
	always @(posedge clk) begin
		scb_pkg::result_t want;
		if (arst_n) begin
			if (cfg_we) begin
				if (cfg_index == scb_pkg::CFG_BLANK_A)
					blank_a = cfg_data;
				else
					blank_b = cfg_data;
			end
			if (s_tvalid && s_tready) begin
				checkerboard_step(scb_pkg::mode_t'(s_tuser), s_tdata);
				beats_in++;
				beat_taken = 1'b1;
			end
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0)
					report_mismatch("unexpected beat, value", int'(m_tdata), 0);
				else begin
					want = expected_results.pop_front();
					if (m_tuser != want.kind)
						report_mismatch("kind", int'(m_tuser), int'(want.kind));
					if (m_tdata != want.value)
						report_mismatch("value", int'(m_tdata), int'(want.value));
					if (m_tlast != want.last)
						report_mismatch("last", int'(m_tlast), int'(want.last));
				end
				beats_out++;
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	// source side: advance on acceptance, insert idle bursts
	always @(negedge clk) begin
		codec_beat_t b;
		if (arst_n && (!s_tvalid || beat_taken)) begin
			beat_taken = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (stim_q.size() > 0) begin
				b = stim_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= b.symbol;
				s_tuser <= b.mode;
				if ($urandom_range(0, 99) < idle_pct)
					send_gap = $urandom_range(1, 5);
			end else
				s_tvalid <= 1'b0;
		end
	end

	// sink side: stall in bursts
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(0, 99) < idle_pct)
					stall_left = $urandom_range(1, 5);
			end
		end
	end

	initial begin
		wait (quiet_cycles >= STALL_LIMIT);
		$display("Stream stalled for %0d cycles", STALL_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	task automatic queue_beat(scb_pkg::mode_t m, logic [7:0] sym);
		codec_beat_t b;
		b.mode = m;
		b.symbol = sym;
		stim_q.push_back(b);
		beats_queued++;
	endtask

	task automatic wait_idle();
		while (beats_in != beats_queued || expected_results.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_blanks(logic [3:0] a, logic [3:0] b);
		cfg_we <= 1'b1;
		cfg_index <= scb_pkg::CFG_BLANK_A;
		cfg_data <= a;
		@(negedge clk);
		cfg_index <= scb_pkg::CFG_BLANK_B;
		cfg_data <= b;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic fill_table(int n);
		int         r;
		logic [7:0] sym;
		if ($urandom_range(0, 3) != 0) begin
			queue_beat(scb_pkg::MODE_CLEAR, 8'($urandom_range(0, 255)));
			key_pool.delete();
		end
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 5)
				sym = 8'd0;
			else if (r < 12 && key_pool.size() > 0)
				sym = key_pool[$urandom_range(0, key_pool.size() - 1)];
			else
				sym = 8'($urandom_range(1, 255));
			queue_beat(scb_pkg::MODE_INSERT, sym);
			if (sym != 8'd0)
				key_pool.push_back(sym);
		end
	endtask

	task automatic encode_run(int n);
		int         r;
		logic [7:0] sym;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 75 && key_pool.size() > 0)
				sym = key_pool[$urandom_range(0, key_pool.size() - 1)];
			else if (r < 85)
				sym = scb_pkg::ASCII_SPACE;
			else
				sym = 8'($urandom_range(0, 255));
			queue_beat(scb_pkg::MODE_ENCODE, sym);
		end
	endtask

	task automatic decode_run(int n);
		int         r;
		logic [3:0] pfx;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				pfx = $urandom_range(0, 1) ? blank_a : blank_b;
				if (pfx <= 4'd9)
					queue_beat(scb_pkg::MODE_DECODE, scb_pkg::ASCII_ZERO + 8'(pfx));
				queue_beat(scb_pkg::MODE_DECODE,
				           scb_pkg::ASCII_ZERO + 8'($urandom_range(0, 9)));
			end else if (r < 80)
				queue_beat(scb_pkg::MODE_DECODE,
				           scb_pkg::ASCII_ZERO + 8'($urandom_range(0, 9)));
			else if (r < 90)
				queue_beat(scb_pkg::MODE_DECODE, scb_pkg::ASCII_SPACE);
			else
				queue_beat(scb_pkg::MODE_DECODE, 8'($urandom_range(0, 255)));
		end
	endtask

	task automatic noise_run(int n);
		for (int i = 0; i < n; i++)
			queue_beat(scb_pkg::mode_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
	endtask

	initial begin
		string seed_keys;
		int    phase_a[PHASES];
		int    phase_b[PHASES];
		seed_keys = "ETAONRISHDE";
		phase_a = '{0, 9, 3, 5, 15, 0, 8, 2};
		phase_b = '{9, 12, 4, 5, 0, 1, 9, 6};
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		idle_pct = 20;

		queue_beat(scb_pkg::MODE_CLEAR, 8'h00);
		queue_beat(scb_pkg::MODE_DECODE, "5");
		queue_beat(scb_pkg::MODE_INSERT, 8'h00);
		for (int i = 0; i < seed_keys.len(); i++)
			queue_beat(scb_pkg::MODE_INSERT, seed_keys[i]);
		queue_beat(scb_pkg::MODE_ENCODE, "E");
		queue_beat(scb_pkg::MODE_ENCODE, "D");
		queue_beat(scb_pkg::MODE_ENCODE, scb_pkg::ASCII_SPACE);
		queue_beat(scb_pkg::MODE_ENCODE, 8'hFF);
		queue_beat(scb_pkg::MODE_ENCODE, 8'h00);
		queue_beat(scb_pkg::MODE_DECODE, "2");
		queue_beat(scb_pkg::MODE_DECODE, "1");
		queue_beat(scb_pkg::MODE_DECODE, "6");
		queue_beat(scb_pkg::MODE_DECODE, "0");
		queue_beat(scb_pkg::MODE_DECODE, "2");
		queue_beat(scb_pkg::MODE_DECODE, scb_pkg::ASCII_SPACE);
		queue_beat(scb_pkg::MODE_DECODE, "x");
		queue_beat(scb_pkg::MODE_DECODE, "9");
		wait_idle();

		for (int ph = 0; ph < PHASES; ph++) begin
			set_blanks(4'(phase_a[ph]), 4'(phase_b[ph]));
			if (ph == PHASES - 1 || ph % 3 == 1)
				idle_pct = 0;
			else
				idle_pct = $urandom_range(10, 35);
			fill_table($urandom_range(10, 34));
			encode_run(18);
			decode_run(15);
			noise_run(8);
			encode_run(8);
			decode_run(8);
			wait_idle();
		end

		$display("Covered %0d input beats and %0d result beats over %0d blank-digit settings",
		         beats_in, beats_out, PHASES + 1);
		if (err_count == 0 && expected_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: straddling_checkerboard_codec.f
hw/rtl/scb_pkg.sv
hw/rtl/scb_table.sv
hw/rtl/straddling_checkerboard_codec.sv
sim/tb_straddling_checkerboard_codec.sv
